[rtl/led_boot_and_breathing_sequencer_core_assert.svh]
// Assertion macros for the LED boot and breathing sequencer.
// Included by files that check their own logic; no other dependencies.
`ifndef LED_BOOT_AND_BREATHING_SEQUENCER_CORE_ASSERT_SVH
`define LED_BOOT_AND_BREATHING_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTH
`define LBBS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LBBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LBBS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define LBBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/lbbs_pkg.sv]
// Shared types and constants for the LED boot and breathing sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lbbs_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // register indexes
  localparam logic [2:0] REG_BOOT_SLIDES   = 3'd0;
  localparam logic [2:0] REG_BOOT_BLINKS   = 3'd1;
  localparam logic [2:0] REG_RAMP_TIME     = 3'd2;
  localparam logic [2:0] REG_FADE_STEP     = 3'd3;
  localparam logic [2:0] REG_FADE_INTERVAL = 3'd4;
  localparam logic [2:0] REG_MAX_LEVEL     = 3'd5;
  localparam logic [2:0] REG_MIN_LEVEL     = 3'd6;

  // register reset values
  localparam logic [3:0]  RST_BOOT_SLIDES   = 4'd3;
  localparam logic [3:0]  RST_BOOT_BLINKS   = 4'd3;
  localparam logic [14:0] RST_RAMP_TIME     = 15'd1000;
  localparam logic [7:0]  RST_FADE_STEP     = 8'd5;
  localparam logic [15:0] RST_FADE_INTERVAL = 16'd20;
  localparam logic [7:0]  RST_MAX_LEVEL     = 8'd255;
  localparam logic [7:0]  RST_MIN_LEVEL     = 8'd0;

  // boot animation thresholds in ms
  localparam logic [15:0] T_SLIDE_GREEN  = 16'd150;
  localparam logic [15:0] T_SLIDE_YELLOW = 16'd300;
  localparam logic [15:0] T_SLIDE_WHITE  = 16'd400;
  localparam logic [15:0] T_SLIDE_OFF    = 16'd500;
  localparam logic [15:0] T_BLINK_WHITE  = 16'd200;
  localparam logic [15:0] T_BLINK_OFF    = 16'd400;
  localparam logic [7:0]  FULL_ON        = 8'd255;

  typedef struct packed {
    logic [15:0] now_ms;
    logic        caps_on;
  } scan_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } led_t;

  typedef struct packed {
    logic [3:0]  boot_slides;
    logic [3:0]  boot_blinks;
    logic [14:0] ramp_time_ms;
    logic [7:0]  fade_step;
    logic [15:0] fade_interval_ms;
    logic [7:0]  max_level;
    logic [7:0]  min_level;
  } cfg_t;

  typedef struct packed {
    logic       load_slides;
    logic       load_blinks;
    logic [3:0] count;
  } preset_t;

  typedef enum logic [1:0] {
    KIND_SLIDE = 2'd0,
    KIND_BLINK = 2'd1,
    KIND_LEVEL = 2'd2
  } kind_t;

  // One scan's worth of LED writes: a prefix of a fixed sequence, or one gray level.
  typedef struct packed {
    kind_t      kind;
    logic [2:0] cnt;
    logic [7:0] lvl;
  } rec_t;

endpackage
`default_nettype wire

[rtl/led_boot_and_breathing_sequencer_core.sv]
// LED boot and breathing sequencer, top level.
// A scan's first LED write passes the record queue, then the output register.
// Throughput: one scan per cycle while the record queue has room; the back end
// drains one LED write per cycle while the output is popped or empty.
// Reset (synchronous): queue and output empty, registers to defaults, boot counters
// preset, timing state and level cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "led_boot_and_breathing_sequencer_core_assert.svh"
module led_boot_and_breathing_sequencer_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire lbbs_pkg::scan_t             scan,
  output logic                             empty,
  input  wire logic                        pop,
  output lbbs_pkg::led_t                   led,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lbbs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lbbs_pkg::DATA_W-1:0] pwdata,
  output logic      [lbbs_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  lbbs_pkg::cfg_t    cfg;
  lbbs_pkg::preset_t preset;
  lbbs_pkg::rec_t    wr_rec, head;
  logic              accept, rec_push, q_nonempty, q_full, head_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  lbbs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .preset  (preset)
  );

  lbbs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .preset   (preset),
    .accept   (accept),
    .scan     (scan),
    .rec_push (rec_push),
    .rec      (wr_rec)
  );

  lbbs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (rec_push),
    .wr_rec   (wr_rec),
    .rd_en    (head_pop),
    .rd_rec   (head),
    .nonempty (q_nonempty),
    .is_full  (q_full)
  );

  lbbs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (q_nonempty),
    .head_pop   (head_pop),
    .led        (led),
    .empty      (empty),
    .pop        (pop)
  );

  `LBBS_ASSERT_NEXT(a_drain_moves, clk, rst, q_nonempty && empty, !empty, "queued record did not reach the output stage")
  `LBBS_ASSERT_SAME(a_no_push_full, clk, rst, q_full, !rec_push, "record pushed into a full queue")
  `LBBS_ASSERT_SAME(a_rec_nonzero, clk, rst, rec_push, wr_rec.cnt != 3'd0 && wr_rec.cnt <= 3'd4, "queued record has a bad write count")
  `LBBS_ASSERT_SAME(a_pop_valid, clk, rst, head_pop, q_nonempty, "back end popped an empty queue")

endmodule
`default_nettype wire

[rtl/lbbs_regs.sv]
// Configuration register file with APB-style access.
// Depends on lbbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbbs_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lbbs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lbbs_pkg::DATA_W-1:0] pwdata,
  output logic      [lbbs_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output lbbs_pkg::cfg_t                  cfg,
  output lbbs_pkg::preset_t               preset
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_slides      <= lbbs_pkg::RST_BOOT_SLIDES;
      cfg.boot_blinks      <= lbbs_pkg::RST_BOOT_BLINKS;
      cfg.ramp_time_ms     <= lbbs_pkg::RST_RAMP_TIME;
      cfg.fade_step        <= lbbs_pkg::RST_FADE_STEP;
      cfg.fade_interval_ms <= lbbs_pkg::RST_FADE_INTERVAL;
      cfg.max_level        <= lbbs_pkg::RST_MAX_LEVEL;
      cfg.min_level        <= lbbs_pkg::RST_MIN_LEVEL;
    end else if (wr_en) begin
      unique case (idx)
        lbbs_pkg::REG_BOOT_SLIDES:   cfg.boot_slides      <= pwdata[3:0];
        lbbs_pkg::REG_BOOT_BLINKS:   cfg.boot_blinks      <= pwdata[3:0];
        lbbs_pkg::REG_RAMP_TIME:     cfg.ramp_time_ms     <= pwdata[14:0];
        lbbs_pkg::REG_FADE_STEP:     cfg.fade_step        <= pwdata[7:0];
        lbbs_pkg::REG_FADE_INTERVAL: cfg.fade_interval_ms <= pwdata[15:0];
        lbbs_pkg::REG_MAX_LEVEL:     cfg.max_level        <= pwdata[7:0];
        lbbs_pkg::REG_MIN_LEVEL:     cfg.min_level        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Writing a boot count also restarts that part of the animation.
  always_comb begin
    preset.load_slides = wr_en && (idx == lbbs_pkg::REG_BOOT_SLIDES);
    preset.load_blinks = wr_en && (idx == lbbs_pkg::REG_BOOT_BLINKS);
    preset.count       = pwdata[3:0];
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      lbbs_pkg::REG_BOOT_SLIDES:   prdata[3:0]  = cfg.boot_slides;
      lbbs_pkg::REG_BOOT_BLINKS:   prdata[3:0]  = cfg.boot_blinks;
      lbbs_pkg::REG_RAMP_TIME:     prdata[14:0] = cfg.ramp_time_ms;
      lbbs_pkg::REG_FADE_STEP:     prdata[7:0]  = cfg.fade_step;
      lbbs_pkg::REG_FADE_INTERVAL: prdata[15:0] = cfg.fade_interval_ms;
      lbbs_pkg::REG_MAX_LEVEL:     prdata[7:0]  = cfg.max_level;
      lbbs_pkg::REG_MIN_LEVEL:     prdata[7:0]  = cfg.min_level;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[rtl/lbbs_front.sv]
// Scan front end: updates boot and breathing state and classifies each scan
// into at most one record of LED writes. Depends on lbbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbbs_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lbbs_pkg::cfg_t    cfg,
  input  wire lbbs_pkg::preset_t preset,
  input  wire logic              accept,
  input  wire lbbs_pkg::scan_t   scan,
  output logic                   rec_push,
  output lbbs_pkg::rec_t         rec
);

  logic [15:0] mark_time, mark_time_next;
  logic [15:0] last_step_time, last_step_time_next;
  logic [7:0]  level, level_next;
  logic [3:0]  slides_left, slides_left_next;
  logic [3:0]  blinks_left, blinks_left_next;
  logic        caps_was_on, caps_was_on_next;

  logic [15:0] elapsed;
  logic [16:0] diff;
  logic        due;
  logic [8:0]  rise_sum;
  logic [8:0]  fall_lim;
  logic [15:0] ramp_twice;
  logic [2:0]  k;

  assign elapsed    = scan.now_ms - mark_time;
  assign diff       = {1'b0, elapsed} - {1'b0, last_step_time};
  assign due        = !diff[16] && (diff[15:0] > cfg.fade_interval_ms);
  assign rise_sum   = {1'b0, level} + {1'b0, cfg.fade_step};
  assign fall_lim   = {1'b0, cfg.min_level} + {1'b0, cfg.fade_step};
  assign ramp_twice = {cfg.ramp_time_ms, 1'b0};

  always_comb begin
    mark_time_next      = mark_time;
    last_step_time_next = last_step_time;
    level_next          = level;
    slides_left_next    = slides_left;
    blinks_left_next    = blinks_left;
    caps_was_on_next    = caps_was_on;
    rec.kind            = lbbs_pkg::KIND_LEVEL;
    rec.cnt             = 3'd0;
    rec.lvl             = '0;
    k                   = 3'd0;

    if (slides_left != 4'd0) begin
      k = {2'b0, elapsed > lbbs_pkg::T_SLIDE_GREEN} + {2'b0, elapsed > lbbs_pkg::T_SLIDE_YELLOW}
        + {2'b0, elapsed > lbbs_pkg::T_SLIDE_WHITE} + {2'b0, elapsed > lbbs_pkg::T_SLIDE_OFF};
      rec.kind = lbbs_pkg::KIND_SLIDE;
      rec.cnt  = k;
      // level follows the red of the final write: green and off are dark red
      priority case (k)
        3'd1, 3'd4: level_next = '0;
        3'd2, 3'd3: level_next = lbbs_pkg::FULL_ON;
        default: ;
      endcase
      if (elapsed > lbbs_pkg::T_SLIDE_OFF) begin
        mark_time_next   = scan.now_ms;
        slides_left_next = slides_left - 4'd1;
      end
    end else if (blinks_left != 4'd0) begin
      k = {2'b0, elapsed > lbbs_pkg::T_BLINK_WHITE} + {2'b0, elapsed > lbbs_pkg::T_BLINK_OFF};
      rec.kind = lbbs_pkg::KIND_BLINK;
      rec.cnt  = k;
      priority case (k)
        3'd1: level_next = lbbs_pkg::FULL_ON;
        3'd2: level_next = '0;
        default: ;
      endcase
      if (elapsed > lbbs_pkg::T_BLINK_OFF) begin
        mark_time_next   = scan.now_ms;
        blinks_left_next = blinks_left - 4'd1;
      end
    end else if (scan.caps_on) begin
      caps_was_on_next = 1'b1;
      priority if (elapsed < {1'b0, cfg.ramp_time_ms}) begin
        if (due && (level < cfg.max_level)) begin
          rec.cnt = 3'd1;
          rec.lvl = (rise_sum > {1'b0, cfg.max_level}) ? cfg.max_level : rise_sum[7:0];
          last_step_time_next = elapsed;
        end
      end else if (elapsed < ramp_twice) begin
        if (due && (level > cfg.min_level)) begin
          rec.cnt = 3'd1;
          rec.lvl = ({1'b0, level} > fall_lim) ? (level - cfg.fade_step) : cfg.min_level;
          last_step_time_next = elapsed;
        end
      end else begin
        rec.cnt             = 3'd1;
        rec.lvl             = '0;
        last_step_time_next = '0;
        mark_time_next      = scan.now_ms;
      end
      if (rec.cnt != 3'd0) begin
        level_next = rec.lvl;
      end
    end else if (caps_was_on) begin
      rec.cnt          = 3'd1;
      rec.lvl          = '0;
      level_next       = '0;
      caps_was_on_next = 1'b0;
    end
  end

  assign rec_push = accept && (rec.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_time      <= '0;
      last_step_time <= '0;
      level          <= '0;
      slides_left    <= lbbs_pkg::RST_BOOT_SLIDES;
      blinks_left    <= lbbs_pkg::RST_BOOT_BLINKS;
      caps_was_on    <= 1'b0;
    end else begin
      if (accept) begin
        mark_time      <= mark_time_next;
        last_step_time <= last_step_time_next;
        level          <= level_next;
        caps_was_on    <= caps_was_on_next;
      end
      // preset the boot counter on the same beat that writes its register
      if (preset.load_slides) begin
        slides_left <= preset.count;
      end else if (accept) begin
        slides_left <= slides_left_next;
      end
      if (preset.load_blinks) begin
        blinks_left <= preset.count;
      end else if (accept) begin
        blinks_left <= blinks_left_next;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/lbbs_fifo.sv]
// Short record queue between the scan front end and the LED write back end.
// Depends on lbbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbbs_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire lbbs_pkg::rec_t wr_rec,
  input  wire logic           rd_en,
  output lbbs_pkg::rec_t      rd_rec,
  output logic                nonempty,
  output logic                is_full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lbbs_pkg::rec_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign nonempty = (count != '0);
  assign is_full  = (count == CNT_W'(DEPTH));
  assign rd_rec   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= bump(rd_ptr);
      end
      priority if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end else begin
        count <= count;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/lbbs_back.sv]
// LED write back end: expands each queued record into its writes, one per beat while
// the output is popped or empty, through a registered output stage. Depends on lbbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbbs_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lbbs_pkg::rec_t head,
  input  wire logic           head_valid,
  output logic                head_pop,
  output lbbs_pkg::led_t      led,
  output logic                empty,
  input  wire logic           pop
);

  logic [1:0]     idx;
  logic           out_valid;
  logic           load;
  logic           is_last;
  lbbs_pkg::led_t next_led;

  function automatic logic [23:0] write_color(lbbs_pkg::kind_t kind, logic [1:0] i,
                                              logic [7:0] lvl);
    logic [23:0] c;
    c = '0;
    unique case (kind)
      lbbs_pkg::KIND_SLIDE: begin
        unique case (i)
          2'd0: c = {8'd0, lbbs_pkg::FULL_ON, 8'd0};
          2'd1: c = {lbbs_pkg::FULL_ON, lbbs_pkg::FULL_ON, 8'd0};
          2'd2: c = {lbbs_pkg::FULL_ON, lbbs_pkg::FULL_ON, lbbs_pkg::FULL_ON};
          default: c = '0;
        endcase
      end
      lbbs_pkg::KIND_BLINK: begin
        c = (i == 2'd0) ? {lbbs_pkg::FULL_ON, lbbs_pkg::FULL_ON, lbbs_pkg::FULL_ON} : '0;
      end
      lbbs_pkg::KIND_LEVEL: c = {lvl, lvl, lvl};
      default: c = '0;
    endcase
    write_color = c;
  endfunction

  assign load     = !out_valid || pop;
  assign is_last  = ({1'b0, idx} == (head.cnt - 3'd1));
  assign head_pop = load && head_valid && is_last;
  assign empty    = !out_valid;

  always_comb begin
    {next_led.red, next_led.green, next_led.blue} = write_color(head.kind, idx, head.lvl);
    next_led.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      led <= next_led;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

[test/tb_top.sv]
// Self-checking bench for the LED boot and breathing sequencer core.
// Drives timer/caps scans through the push/full queue, predicts every LED write,
// and checks pops against the prediction; needs lbbs_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;

  localparam int RUN_LIMIT_NS  = 3_000_000;
  localparam int DRAIN_LIMIT   = 20_000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PRINT_CAP     = 100;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          push = 1'b0;
  logic                          full;
  lbbs_pkg::scan_t               scan = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  lbbs_pkg::led_t                led;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [lbbs_pkg::ADDR_W-1:0]   paddr = '0;
  logic [lbbs_pkg::DATA_W-1:0]   pwdata = '0;
  logic [lbbs_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  led_boot_and_breathing_sequencer_core dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .scan(scan),
    .empty(empty), .pop(pop), .led(led),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // stimulus and scoreboard
  lbbs_pkg::scan_t scans_to_send[$];
  lbbs_pkg::led_t  led_due[$];
  bit              scan_went = 1'b0;
  int              gap_pct = 8;
  int              stall_pct = 45;
  int              mismatches = 0;
  logic [15:0]     timer_ms = '0;
  bit              caps_now = 1'b1;

  // sequencer copy: registers and state
  lbbs_pkg::cfg_t  cfg;
  logic [15:0]     mark_ms;
  logic [15:0]     step_ms;
  logic [7:0]      level;
  logic [3:0]      slides_left;
  logic [3:0]      blinks_left;
  bit              caps_held;
  int              writes_this_scan;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic void put_led(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b);
    lbbs_pkg::led_t w;
    w.red = r;
    w.green = g;
    w.blue = b;
    w.last = 1'b0;
    led_due.push_back(w);
    level = r;
    writes_this_scan++;
  endfunction

  function automatic void predict_scan(input lbbs_pkg::scan_t s);
    logic [15:0]    e;
    int             diff;
    int             v;
    bit             due;
    lbbs_pkg::led_t w;
    writes_this_scan = 0;
    if (slides_left != 0 || blinks_left != 0) begin
      if (slides_left != 0) begin
        e = s.now_ms - mark_ms;
        if (e > lbbs_pkg::T_SLIDE_GREEN) put_led(8'd0, lbbs_pkg::FULL_ON, 8'd0);
        if (e > lbbs_pkg::T_SLIDE_YELLOW) put_led(lbbs_pkg::FULL_ON, lbbs_pkg::FULL_ON, 8'd0);
        if (e > lbbs_pkg::T_SLIDE_WHITE)
          put_led(lbbs_pkg::FULL_ON, lbbs_pkg::FULL_ON, lbbs_pkg::FULL_ON);
        if (e > lbbs_pkg::T_SLIDE_OFF) begin
          put_led(8'd0, 8'd0, 8'd0);
          mark_ms = s.now_ms;
          slides_left = slides_left - 4'd1;
        end
      end
      // a slide that just ended hands over with a fresh mark
      if (slides_left == 0 && blinks_left != 0) begin
        e = s.now_ms - mark_ms;
        if (e > lbbs_pkg::T_BLINK_WHITE)
          put_led(lbbs_pkg::FULL_ON, lbbs_pkg::FULL_ON, lbbs_pkg::FULL_ON);
        if (e > lbbs_pkg::T_BLINK_OFF) begin
          put_led(8'd0, 8'd0, 8'd0);
          mark_ms = s.now_ms;
          blinks_left = blinks_left - 4'd1;
        end
      end
    end else if (s.caps_on) begin
      e = s.now_ms - mark_ms;
      diff = int'(e) - int'(step_ms);
      due = diff > int'(cfg.fade_interval_ms);
      if (int'(e) < int'(cfg.ramp_time_ms)) begin
        if (due && level < cfg.max_level) begin
          v = int'(level) + int'(cfg.fade_step);
          if (v > int'(cfg.max_level)) v = cfg.max_level;
          put_led(8'(v), 8'(v), 8'(v));
          step_ms = e;
        end
      end else if (int'(e) < 2 * int'(cfg.ramp_time_ms)) begin
        if (due && level > cfg.min_level) begin
          if (int'(level) > int'(cfg.min_level) + int'(cfg.fade_step))
            v = int'(level) - int'(cfg.fade_step);
          else
            v = cfg.min_level;
          put_led(8'(v), 8'(v), 8'(v));
          step_ms = e;
        end
      end else begin
        put_led(8'd0, 8'd0, 8'd0);
        step_ms = '0;
        mark_ms = s.now_ms;
      end
      caps_held = 1'b1;
    end else if (caps_held) begin
      put_led(8'd0, 8'd0, 8'd0);
      caps_held = 1'b0;
    end
    if (writes_this_scan > 0) begin
      w = led_due.pop_back();
      w.last = 1'b1;
      led_due.push_back(w);
    end
  endfunction

  // sender: hold the beat until taken, then maybe idle
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || scan_went) begin
      if (scans_to_send.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        scan <= scans_to_send.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
    scan_went = 1'b0;
  end

  always @(negedge clk) begin
    pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : monitor
    lbbs_pkg::led_t want;
    if (!rst) begin
      if (push && !full) begin
        predict_scan(scan);
        scan_went = 1'b1;
      end
      if (pop && !empty) begin
        if (led_due.size() == 0) begin
          report_mismatch($sformatf("LED write with none due: %h", led));
        end else begin
          want = led_due.pop_front();
          compare_field("red", led.red, want.red);
          compare_field("green", led.green, want.green);
          compare_field("blue", led.blue, want.blue);
          compare_field("last", 8'(led.last), 8'(want.last));
        end
      end
    end
  end

  task automatic reg_access(input logic [2:0] idx, input bit wr, input logic [31:0] data);
    logic [31:0] want;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      case (idx)
        lbbs_pkg::REG_BOOT_SLIDES: begin
          cfg.boot_slides = data[3:0];
          slides_left = data[3:0];
        end
        lbbs_pkg::REG_BOOT_BLINKS: begin
          cfg.boot_blinks = data[3:0];
          blinks_left = data[3:0];
        end
        lbbs_pkg::REG_RAMP_TIME:     cfg.ramp_time_ms = data[14:0];
        lbbs_pkg::REG_FADE_STEP:     cfg.fade_step = data[7:0];
        lbbs_pkg::REG_FADE_INTERVAL: cfg.fade_interval_ms = data[15:0];
        lbbs_pkg::REG_MAX_LEVEL:     cfg.max_level = data[7:0];
        lbbs_pkg::REG_MIN_LEVEL:     cfg.min_level = data[7:0];
        default: ;
      endcase
    end else begin
      case (idx)
        lbbs_pkg::REG_BOOT_SLIDES:   want = 32'(cfg.boot_slides);
        lbbs_pkg::REG_BOOT_BLINKS:   want = 32'(cfg.boot_blinks);
        lbbs_pkg::REG_RAMP_TIME:     want = 32'(cfg.ramp_time_ms);
        lbbs_pkg::REG_FADE_STEP:     want = 32'(cfg.fade_step);
        lbbs_pkg::REG_FADE_INTERVAL: want = 32'(cfg.fade_interval_ms);
        lbbs_pkg::REG_MAX_LEVEL:     want = 32'(cfg.max_level);
        lbbs_pkg::REG_MIN_LEVEL:     want = 32'(cfg.min_level);
        default:                     want = '0;
      endcase
      if (prdata !== want)
        report_mismatch($sformatf("register %0d reads %0d want %0d", idx, prdata, want));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_back_all();
    for (int i = lbbs_pkg::REG_BOOT_SLIDES; i <= lbbs_pkg::REG_MIN_LEVEL; i++)
      reg_access(3'(i), 1'b0, '0);
  endtask

  task automatic configure(input logic [3:0] slides, input logic [3:0] blinks,
                           input logic [14:0] ramp, input logic [7:0] fstep,
                           input logic [15:0] interval, input logic [7:0] hi,
                           input logic [7:0] lo);
    reg_access(lbbs_pkg::REG_BOOT_SLIDES, 1'b1, 32'(slides));
    reg_access(lbbs_pkg::REG_BOOT_BLINKS, 1'b1, 32'(blinks));
    reg_access(lbbs_pkg::REG_RAMP_TIME, 1'b1, 32'(ramp));
    reg_access(lbbs_pkg::REG_FADE_STEP, 1'b1, 32'(fstep));
    reg_access(lbbs_pkg::REG_FADE_INTERVAL, 1'b1, 32'(interval));
    reg_access(lbbs_pkg::REG_MAX_LEVEL, 1'b1, 32'(hi));
    reg_access(lbbs_pkg::REG_MIN_LEVEL, 1'b1, 32'(lo));
    read_back_all();
  endtask

  task automatic queue_scan(input logic [15:0] now, input bit caps);
    lbbs_pkg::scan_t s;
    s.now_ms = now;
    s.caps_on = caps;
    scans_to_send.push_back(s);
    timer_ms = now;
  endtask

  // mostly steady timer progress; a few long gaps and wild jumps
  task automatic queue_random_scans(input int n);
    int pick;
    int gap;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) gap = $urandom_range(0, 40);
      else if (pick < 85) gap = $urandom_range(41, 200);
      else if (pick < 95) gap = $urandom_range(201, 700);
      else gap = $urandom_range(0, 65535);
      if ($urandom_range(0, 11) == 0) caps_now = !caps_now;
      queue_scan(timer_ms + 16'(gap), caps_now);
    end
  endtask

  // wait for every beat to go in and every LED write to come out
  task automatic drain();
    int waited;
    waited = 0;
    while ((scans_to_send.size() != 0 || push || led_due.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [3:0]  r_slides;
    logic [3:0]  r_blinks;
    logic [14:0] r_ramp;
    logic [7:0]  r_step;
    logic [15:0] r_interval;
    logic [7:0]  r_hi;
    logic [7:0]  r_lo;

    cfg.boot_slides = lbbs_pkg::RST_BOOT_SLIDES;
    cfg.boot_blinks = lbbs_pkg::RST_BOOT_BLINKS;
    cfg.ramp_time_ms = lbbs_pkg::RST_RAMP_TIME;
    cfg.fade_step = lbbs_pkg::RST_FADE_STEP;
    cfg.fade_interval_ms = lbbs_pkg::RST_FADE_INTERVAL;
    cfg.max_level = lbbs_pkg::RST_MAX_LEVEL;
    cfg.min_level = lbbs_pkg::RST_MIN_LEVEL;
    mark_ms = '0;
    step_ms = '0;
    level = '0;
    slides_left = lbbs_pkg::RST_BOOT_SLIDES;
    blinks_left = lbbs_pkg::RST_BOOT_BLINKS;
    caps_held = 1'b0;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    repeat (4) @(negedge clk);
    read_back_all();

    // reset settings: walk the whole boot, then breathing corners
    queue_scan(16'd0, 1'b1);
    queue_scan(16'd151, 1'b0);
    queue_scan(16'd301, 1'b1);
    queue_scan(16'd401, 1'b1);
    queue_scan(16'd501, 1'b1);
    queue_scan(16'd1101, 1'b0);
    queue_scan(16'd1701, 1'b1);   // last slide ends, blinks start from zero
    queue_scan(16'd2102, 1'b1);
    queue_scan(16'd2503, 1'b0);
    queue_scan(16'd2904, 1'b1);   // boot ends, nothing else this scan
    queue_scan(16'd2925, 1'b1);
    queue_scan(16'd2924, 1'b1);   // timer stepped back: negative difference
    queue_scan(16'd2950, 1'b0);   // caps release
    queue_scan(16'd2960, 1'b0);
    queue_scan(16'd65535, 1'b1);  // ramp end
    queue_scan(16'd30, 1'b1);     // timer wrap
    caps_now = 1'b1;
    queue_random_scans(70);
    drain();

    configure(4'd0, 4'd1, 15'd0, 8'd255, 16'd0, 8'd255, 8'd0);
    queue_random_scans(30);
    drain();

    gap_pct = 45;
    stall_pct = 8;
    configure(4'd15, 4'd15, 15'd32767, 8'd1, 16'd65535, 8'd0, 8'd255);
    queue_random_scans(70);
    drain();

    configure(4'd0, 4'd0, 15'd60, 8'd255, 16'd0, 8'd200, 8'd100);
    queue_random_scans(70);
    drain();

    gap_pct = 0;
    stall_pct = 0;
    r_slides = 4'($urandom_range(0, 2));
    r_blinks = 4'($urandom_range(0, 2));
    r_ramp = 15'($urandom_range(1, 400));
    r_step = 8'($urandom_range(1, 60));
    r_interval = 16'($urandom_range(0, 50));
    r_hi = 8'($urandom_range(0, 255));
    r_lo = 8'($urandom_range(0, 255));
    configure(r_slides, r_blinks, r_ramp, r_step, r_interval, r_hi, r_lo);
    queue_random_scans(100);
    drain();

    configure(4'd1, 4'd0, 15'd200, 8'd30, 16'd10, 8'd250, 8'd40);
    queue_random_scans(80);
    drain();

    if (led_due.size() != 0)
      report_mismatch($sformatf("%0d LED writes never came", led_due.size()));
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/lbbs_pkg.sv
rtl/lbbs_regs.sv
rtl/lbbs_front.sv
rtl/lbbs_fifo.sv
rtl/lbbs_back.sv
rtl/led_boot_and_breathing_sequencer_core.sv
test/tb_top.sv
